[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bar graph block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

[hdl/bgl_pkg.sv]
// ----------------------------------------------------------------------------
// Bar graph LED package
// Shared constants and types of the bar graph to LED row converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bgl_pkg;

  localparam int CELL_COUNT = 32;
  localparam int CELL_AW    = 5;
  localparam int COUNT_W    = 6;
  localparam int HEIGHT_W   = 8;

  localparam logic [COUNT_W-1:0] MAX_BARS  = 6'd32;
  localparam logic [COUNT_W-1:0] ROW_LIMIT = 6'd32;

  localparam logic [2:0] REG_DIRECTION = 3'd0;
  localparam logic [2:0] REG_FLIP_ROWS = 3'd1;
  localparam logic [2:0] REG_FLIP_COLS = 3'd2;
  localparam logic [2:0] REG_BAR_COUNT = 3'd3;
  localparam logic [2:0] REG_ROW_COUNT = 3'd4;

  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [CELL_COUNT-1:0][HEIGHT_W-1:0] heights_t;

  typedef struct packed {
    logic we;
    logic rot_dn;
    logic rot_up;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/bar_graph_to_led_rows.sv]
// Loading: one bar height word per cycle; a frame takes bar_count (vertical) or row_count
// (horizontal) words, each clamped to 1..32. The final word moves the block to the emit
// state, which loads rows into the output register at one per cycle unless out_ready_i
// stalls; a frame has row_count rows (1..32). Input is not taken while a frame is being
// emitted. Reset (asynchronous, active low) restores register defaults, clears the load
// count and empties the output register; stored heights are undefined until written.
// ----------------------------------------------------------------------------
// Bar graph to LED rows
// Loads a frame of bar heights into a ring of cells and emits the LED rows.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_graph_to_led_rows (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  bar_height_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       row_index_o,
  output logic [31:0]      row_bits_o,
  output logic             last_row_o
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  localparam int AW = bgl_pkg::CELL_AW;
  localparam int CW = bgl_pkg::COUNT_W;

  logic          direction_q;
  logic          flip_rows_q;
  logic          flip_cols_q;
  logic [CW-1:0] bar_count_q;
  logic [CW-1:0] row_count_q;

  logic          state_q;
  logic [AW-1:0] load_count_q;
  logic [AW-1:0] row_cnt_q;

  logic          out_valid_q;
  logic [AW-1:0] row_index_q;
  logic [31:0]   row_bits_q;
  logic          last_row_q;

  logic [CW-1:0] bars;
  logic [CW-1:0] rows;
  logic [CW-1:0] target;
  logic [CW-1:0] load_next;
  logic [AW-1:0] rows_m1;
  logic [AW-1:0] src;
  logic          in_fire;
  logic          frame_done;
  logic          emit_fire;
  logic          row_last;

  bgl_pkg::heights_t   heights;
  bgl_pkg::height_t    tap;
  bgl_pkg::cell_ctrl_t ctrl [bgl_pkg::CELL_COUNT];
  logic [31:0]         row_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      flip_rows_q <= 1'b0;
      flip_cols_q <= 1'b0;
      bar_count_q <= 6'd32;
      row_count_q <= 6'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bgl_pkg::REG_DIRECTION: direction_q <= cfg_data_i[0];
        bgl_pkg::REG_FLIP_ROWS: flip_rows_q <= cfg_data_i[0];
        bgl_pkg::REG_FLIP_COLS: flip_cols_q <= cfg_data_i[0];
        bgl_pkg::REG_BAR_COUNT: bar_count_q <= cfg_data_i;
        bgl_pkg::REG_ROW_COUNT: row_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (bar_count_q == '0) begin
      bars = 6'd1;
    end else if (bar_count_q > bgl_pkg::MAX_BARS) begin
      bars = bgl_pkg::MAX_BARS;
    end else begin
      bars = bar_count_q;
    end
    priority if (row_count_q == '0) begin
      rows = 6'd1;
    end else if (row_count_q > bgl_pkg::ROW_LIMIT) begin
      rows = bgl_pkg::ROW_LIMIT;
    end else begin
      rows = row_count_q;
    end
  end

  assign target     = direction_q ? rows : bars;
  assign load_next  = {1'b0, load_count_q} + 6'd1;
  assign frame_done = load_next >= target;
  assign rows_m1    = AW'(rows - 6'd1);
  assign src        = flip_rows_q ? (rows_m1 - row_cnt_q) : row_cnt_q;
  assign row_last   = row_cnt_q == rows_m1;

  assign in_ready_o = state_q == ST_LOAD;
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      load_count_q <= '0;
      row_cnt_q    <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (frame_done) begin
              load_count_q <= '0;
              row_cnt_q    <= '0;
              state_q      <= ST_EMIT;
            end else begin
              load_count_q <= AW'(load_next);
            end
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            row_cnt_q <= row_cnt_q + 5'd1;
            if (row_last) begin
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  for (genvar k = 0; k < bgl_pkg::CELL_COUNT; k++) begin : g_cell
    localparam int NXT = (k + 1) % bgl_pkg::CELL_COUNT;
    localparam int PRV = (k + bgl_pkg::CELL_COUNT - 1) % bgl_pkg::CELL_COUNT;

    assign ctrl[k].we     = in_fire && (load_count_q == AW'(k));
    assign ctrl[k].rot_dn = emit_fire && direction_q && !flip_rows_q;
    assign ctrl[k].rot_up = emit_fire && direction_q && flip_rows_q;

    bgl_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl[k]),
      .wdata_i  (bar_height_i),
      .next_i   (heights[NXT]),
      .prev_i   (heights[PRV]),
      .height_o (heights[k])
    );
  end

  assign tap = flip_rows_q ? heights[rows_m1] : heights[0];

  bgl_row u_row (
    .heights_i    (heights),
    .tap_i        (tap),
    .src_i        (src),
    .bars_i       (bars),
    .horizontal_i (direction_q),
    .flip_cols_i  (flip_cols_q),
    .bits_o       (row_bits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      row_index_q <= row_cnt_q;
      row_bits_q  <= row_bits;
      last_row_q  <= row_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_index_q;
  assign row_bits_o  = row_bits_q;
  assign last_row_o  = last_row_q;

endmodule

`default_nettype wire

[hdl/bgl_cell.sv]
// ----------------------------------------------------------------------------
// Bar graph LED cell
// Holds one bar height; loads a new word or takes its neighbor's height.
// ----------------------------------------------------------------------------
`default_nettype none

module bgl_cell (
  input  wire logic               clk_i,
  input  wire bgl_pkg::cell_ctrl_t ctrl_i,
  input  wire bgl_pkg::height_t   wdata_i,
  input  wire bgl_pkg::height_t   next_i,
  input  wire bgl_pkg::height_t   prev_i,
  output bgl_pkg::height_t        height_o
);

  bgl_pkg::height_t height_d;
  bgl_pkg::height_t height_q;

  always_comb begin
    priority if (ctrl_i.we) begin
      height_d = wdata_i;
    end else if (ctrl_i.rot_dn) begin
      height_d = next_i;
    end else if (ctrl_i.rot_up) begin
      height_d = prev_i;
    end else begin
      height_d = height_q;
    end
  end

  always_ff @(posedge clk_i) begin
    height_q <= height_d;
  end

  assign height_o = height_q;

endmodule

`default_nettype wire

[hdl/bgl_row.sv]
// ----------------------------------------------------------------------------
// Bar graph LED row former
// Builds the 32-bit LED row from the cell heights and applies the column flip.
// ----------------------------------------------------------------------------
`default_nettype none

module bgl_row (
  input  wire bgl_pkg::heights_t           heights_i,
  input  wire bgl_pkg::height_t            tap_i,
  input  wire logic [bgl_pkg::CELL_AW-1:0] src_i,
  input  wire logic [bgl_pkg::COUNT_W-1:0] bars_i,
  input  wire logic                        horizontal_i,
  input  wire logic                        flip_cols_i,
  output logic [bgl_pkg::CELL_COUNT-1:0]   bits_o
);

  logic [bgl_pkg::CELL_COUNT-1:0] raw;

  always_comb begin
    for (int b = 0; b < bgl_pkg::CELL_COUNT; b++) begin
      if (horizontal_i) begin
        raw[b] = tap_i > bgl_pkg::HEIGHT_W'(b);
      end else begin
        raw[b] = (heights_i[b] > {3'b000, src_i}) &&
                 (bgl_pkg::COUNT_W'(b) < bars_i);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < bgl_pkg::CELL_COUNT; b++) begin
      bits_o[b] = flip_cols_i ? raw[bgl_pkg::CELL_COUNT-1-b] : raw[b];
    end
  end

endmodule

`default_nettype wire

[hdl/bgl_checker.sv]
// ----------------------------------------------------------------------------
// Bar graph LED checker
// Port-level checks of frame emission, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bgl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [4:0]  row_index_o,
  input wire logic [31:0] row_bits_o,
  input wire logic        last_row_o
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=>
    (out_valid_o && $stable(row_bits_o) && $stable(row_index_o)),
    "Stalled output word changed.")

  `ASSERT_NEVER(a_no_load_mid_frame, clk_i, rst_ni,
    out_valid_o && !last_row_o && in_ready_o,
    "Input taken while a frame is still being emitted.")

  `ASSERT_CLK(a_row_follows, clk_i, rst_ni,
    (out_valid_o && out_ready_i && !last_row_o) |=>
    (out_valid_o && (row_index_o == $past(row_index_o) + 5'd1)),
    "Rows of a frame did not follow back to back in order.")

  `ASSERT_CLK(a_frame_ends, clk_i, rst_ni,
    (out_valid_o && out_ready_i && last_row_o) |=> (!out_valid_o || (row_index_o == 5'd0)),
    "Word after the final row of a frame did not start a new frame.")

endmodule

bind bar_graph_to_led_rows bgl_checker u_bgl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .row_index_o (row_index_o),
  .row_bits_o  (row_bits_o),
  .last_row_o  (last_row_o)
);

`default_nettype wire

[tb/tb_bar_graph_to_led_rows.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bar graph to LED rows testbench
// Sends bar height words to the converter, predicts the LED rows of every
// frame from a private copy of the block state and checks each row that
// comes out. Directed cases come first, then random frames under changing
// settings, with random idle cycles on both handshakes.
// ----------------------------------------------------------------------------

module tb_bar_graph_to_led_rows;

  localparam logic [2:0] REG_SPARE_FIRST  = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST   = 3'd7;

  localparam logic [5:0] RESET_ROW_COUNT = 6'd8;
  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_WORDS    = 300;

  typedef struct packed {
    logic [4:0]  index;
    logic [31:0] bits;
    logic        last;
  } led_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [2:0]       cfg_index_i;
  logic [5:0]       cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  bgl_pkg::height_t bar_height_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [4:0]       row_index_o;
  logic [31:0]      row_bits_o;
  logic             last_row_o;

  bar_graph_to_led_rows dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .bar_height_i (bar_height_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_index_o  (row_index_o),
    .row_bits_o   (row_bits_o),
    .last_row_o   (last_row_o)
  );

  logic             cfg_direction;
  logic             cfg_flip_rows;
  logic             cfg_flip_columns;
  logic [5:0]       cfg_bar_count;
  logic [5:0]       cfg_row_count;
  bgl_pkg::height_t heights_held [bgl_pkg::CELL_COUNT];
  logic [5:0]       words_loaded;
  led_row_t         expected_rows [$];
  led_row_t         want_row;

  int  errors = 0;
  int  words_sent = 0;
  int  frames_emitted = 0;
  int  rows_checked = 0;
  int  reg_writes = 0;
  int  idle_cycles = 0;
  int  hold_req = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  logic tx_gaps_on = 1'b0;
  logic rx_stalls_on = 1'b0;

  always #4 clk_i = ~clk_i;

  function automatic int clamp_count(logic [5:0] value, logic [5:0] hi);
    if (value == 6'd0) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  function automatic int frame_target();
    return cfg_direction ? clamp_count(cfg_row_count, bgl_pkg::ROW_LIMIT)
                         : clamp_count(cfg_bar_count, bgl_pkg::MAX_BARS);
  endfunction

  // Stores one height and, once the frame is complete, queues all its rows.
  function automatic void load_height(bgl_pkg::height_t h);
    int bars;
    int rows;
    int src;
    logic [31:0] bits;
    led_row_t row;
    bars = clamp_count(cfg_bar_count, bgl_pkg::MAX_BARS);
    rows = clamp_count(cfg_row_count, bgl_pkg::ROW_LIMIT);
    heights_held[words_loaded[4:0]] = h;
    words_loaded = words_loaded + 6'd1;
    if (words_loaded < frame_target()) return;
    words_loaded = '0;
    frames_emitted++;
    for (int i = 0; i < rows; i++) begin
      src = cfg_flip_rows ? rows - 1 - i : i;
      bits = '0;
      if (cfg_direction) begin
        bits = (heights_held[src] >= 8'd32) ? '1 : (32'd1 << heights_held[src]) - 32'd1;
      end else begin
        for (int b = 0; b < bars; b++) begin
          if (heights_held[b] > src) bits[b] = 1'b1;
        end
      end
      for (int k = 0; k < 32; k++) begin
        row.bits[k] = cfg_flip_columns ? bits[31-k] : bits[k];
      end
      row.index = 5'(i);
      row.last = (i == rows - 1);
      expected_rows.push_back(row);
    end
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic bgl_pkg::height_t pick_height();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    if (sel < 7) return 8'($urandom_range(0, 33));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [5:0] pick_count();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
    if (sel == 1) return 6'd32;
    if (sel == 2) return 6'($urandom_range(9, 31));
    return 6'($urandom_range(1, 8));
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [5:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    case (idx)
      bgl_pkg::REG_DIRECTION: cfg_direction = value[0];
      bgl_pkg::REG_FLIP_ROWS: cfg_flip_rows = value[0];
      bgl_pkg::REG_FLIP_COLS: cfg_flip_columns = value[0];
      bgl_pkg::REG_BAR_COUNT: cfg_bar_count = value;
      bgl_pkg::REG_ROW_COUNT: cfg_row_count = value;
      default: ;
    endcase
  endtask

  task automatic send_bar(bgl_pkg::height_t h);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    bar_height_i <= h;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    load_height(h);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_vertical_bars();
    write_reg(bgl_pkg::REG_BAR_COUNT, 6'd3);
    send_bar(8'd0);
    send_bar(8'd255);
    send_bar(8'd5);
    wait_drained();
  endtask

  task automatic test_count_clamping();
    write_reg(bgl_pkg::REG_BAR_COUNT, 6'd0);
    write_reg(bgl_pkg::REG_ROW_COUNT, 6'd63);
    send_bar(8'd31);
    wait_drained();
  endtask

  task automatic test_horizontal_runs();
    write_reg(bgl_pkg::REG_DIRECTION, 6'd1);
    write_reg(bgl_pkg::REG_ROW_COUNT, 6'd5);
    write_reg(bgl_pkg::REG_BAR_COUNT, 6'd40);
    send_bar(8'd0);
    send_bar(8'd1);
    send_bar(8'd31);
    send_bar(8'd32);
    send_bar(8'd255);
    wait_drained();
  endtask

  task automatic test_flips();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    write_reg(bgl_pkg::REG_FLIP_ROWS, 6'd1);
    write_reg(bgl_pkg::REG_FLIP_COLS, 6'd1);
    write_reg(bgl_pkg::REG_ROW_COUNT, 6'd3);
    send_bar(8'd1);
    send_bar(8'd7);
    send_bar(8'd33);
    wait_drained();
    write_reg(bgl_pkg::REG_DIRECTION, 6'd0);
    write_reg(bgl_pkg::REG_BAR_COUNT, 6'd2);
    write_reg(bgl_pkg::REG_ROW_COUNT, 6'd2);
    send_bar(8'd1);
    send_bar(8'd2);
    wait_drained();
    write_reg(bgl_pkg::REG_FLIP_ROWS, 6'd0);
    write_reg(bgl_pkg::REG_FLIP_COLS, 6'd0);
  endtask

  // Writes to indexes past the register list must leave every setting alone.
  task automatic test_spare_index();
    for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++) begin
      write_reg(3'(idx), 6'h3F);
    end
    write_reg(bgl_pkg::REG_DIRECTION, 6'd1);
    write_reg(bgl_pkg::REG_ROW_COUNT, 6'd0);
    send_bar(8'd4);
    wait_drained();
  endtask

  // Settings change mid-frame without clearing the load position; lowering
  // the frame size below it emits the frame on the next word.
  task automatic test_lowered_target();
    write_reg(bgl_pkg::REG_DIRECTION, 6'd0);
    write_reg(bgl_pkg::REG_BAR_COUNT, 6'd6);
    write_reg(bgl_pkg::REG_ROW_COUNT, 6'd4);
    send_bar(8'd3);
    send_bar(8'd0);
    wait_drained();
    write_reg(bgl_pkg::REG_FLIP_COLS, 6'd1);
    send_bar(8'd2);
    send_bar(8'd4);
    wait_drained();
    write_reg(bgl_pkg::REG_BAR_COUNT, 6'd2);
    send_bar(8'd1);
    wait_drained();
    write_reg(bgl_pkg::REG_FLIP_COLS, 6'd0);
  endtask

  task automatic test_output_stall();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b1;
    write_reg(bgl_pkg::REG_DIRECTION, 6'd1);
    write_reg(bgl_pkg::REG_ROW_COUNT, 6'd4);
    hold_req = HOLD_OFF_CYCLES;
    repeat (12) send_bar(pick_height());
    wait_drained();
  endtask

  task automatic test_random_frames();
    int n;
    int stop_at;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      wait_drained();
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) write_reg(bgl_pkg::REG_DIRECTION, 6'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(bgl_pkg::REG_FLIP_ROWS, 6'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(bgl_pkg::REG_FLIP_COLS, 6'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(bgl_pkg::REG_BAR_COUNT, pick_count());
      if ($urandom_range(0, 1)) write_reg(bgl_pkg::REG_ROW_COUNT, pick_count());
      n = frame_target() * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(0, frame_target() - 1);
      repeat (n) begin
        send_bar(pick_height());
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    bar_height_i = '0;
    cfg_direction = 1'b0;
    cfg_flip_rows = 1'b0;
    cfg_flip_columns = 1'b0;
    cfg_bar_count = bgl_pkg::MAX_BARS;
    cfg_row_count = RESET_ROW_COUNT;
    words_loaded = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_vertical_bars();
    test_count_clamping();
    test_horizontal_runs();
    test_flips();
    test_spare_index();
    test_lowered_target();
    test_output_stall();
    test_random_frames();

    $display("Sent %0d height words in %0d frames; %0d rows checked after %0d register writes.",
             words_sent, frames_emitted, rows_checked, reg_writes);
    $display("Both bar directions, both flips, clamped counts, spare indexes and stalls ran.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Output side: random stalls, plus a long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected row: row_index %0d, row_bits %h, last_row %b",
               row_index_o, row_bits_o, last_row_o);
        errors++;
      end else begin
        want_row = expected_rows.pop_front();
        rows_checked++;
        if (row_index_o !== want_row.index) begin
          $error("row_index: expected %0d, got %0d", want_row.index, row_index_o);
          errors++;
        end
        if (row_bits_o !== want_row.bits) begin
          $error("row_bits: expected %h, got %h", want_row.bits, row_bits_o);
          errors++;
        end
        if (last_row_o !== want_row.last) begin
          $error("last_row: expected %b, got %b", want_row.last, last_row_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
